// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/gcl_pkg.sv =====
package gcl_pkg;

   localparam int FontW  = 8;
   localparam int CodeW  = 16;
   localparam int IndexW = 6;
   localparam int CfgW   = 7;

   // Glyph key held by each cell
   typedef struct packed {
      logic [FontW-1:0] font;
      logic [CodeW-1:0] code;
   } gcl_key_type;

endpackage

// ===== hw/rtl/gcl_req_if.sv =====
interface gcl_req_if;
   import gcl_pkg::*;

   logic             valid;
   logic             ready;
   logic [FontW-1:0] font_id;
   logic [CodeW-1:0] char_code;

   modport source (output valid, output font_id, output char_code, input ready);
   modport sink (input valid, input font_id, input char_code, output ready);
endinterface

// ===== hw/rtl/gcl_rsp_if.sv =====
interface gcl_rsp_if;
   import gcl_pkg::*;

   logic              valid;
   logic              ready;
   logic              hit;
   logic [IndexW-1:0] entry_index;
   logic              evicted;
   logic [FontW-1:0]  evicted_font;
   logic [CodeW-1:0]  evicted_code;

   modport source (output valid, output hit, output entry_index, output evicted,
                   output evicted_font, output evicted_code, input ready);
   modport sink (input valid, input hit, input entry_index, input evicted,
                 input evicted_font, input evicted_code, output ready);
endinterface

// ===== hw/rtl/gcl_cell.sv =====
// One place in the recency row. Position 0 is the most recent.
module gcl_cell #(
   parameter int IDX_W = 6,
   parameter int POS   = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clear,
   input  logic                 update,
   input  logic [IDX_W-1:0]     tgt_pos,
   input  gcl_pkg::gcl_key_type cmp_key,
   input  logic                 prev_valid,
   input  logic [IDX_W-1:0]     prev_idx,
   input  gcl_pkg::gcl_key_type prev_key,
   output logic                 valid,
   output logic [IDX_W-1:0]     idx,
   output gcl_pkg::gcl_key_type key,
   output logic                 match,
   output logic                 sel
);
   import gcl_pkg::*;

   logic                 valid_ff, valid_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   gcl_key_type          key_ff, key_in;
   logic                 shift;

   // cells at or below the target position take their neighbour's content
   assign shift = update && (IDX_W'(POS) <= tgt_pos);

   always_comb begin
      valid_in = shift ? prev_valid : valid_ff;
      idx_in   = shift ? prev_idx : idx_ff;
      key_in   = shift ? prev_key : key_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= 1'b0;
         idx_ff   <= IDX_W'(POS);
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   // tag compare and position select
   assign match = valid_ff && (key_ff == cmp_key);
   assign sel   = (IDX_W'(POS) == tgt_pos);
   assign valid = valid_ff;
   assign idx   = idx_ff;
   assign key   = key_ff;

endmodule

// ===== hw/rtl/glyph_cache_lru_lookup_top.sv =====
// The result is registered once the item has passed the tag compare across the cell row
// and then the recency shift and result load; a stalled result holds the update back.
// A new item is taken only once the previous one has left the compare stage and its update lands.
// Reset (synchronous): cache empty, recency row in index order, limit = 64 entries (or CACHE_ENTRIES if fewer).
// A csr write sets the limit and empties the cache.
module glyph_cache_lru_lookup_top #(
   parameter int CACHE_ENTRIES = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   gcl_req_if.sink                  req_chan,
   gcl_rsp_if.source                rsp_chan,
   input  logic                     csr_wr_en,
   input  logic [gcl_pkg::CfgW-1:0] csr_wr_data
);
   import gcl_pkg::*;

   localparam int N      = CACHE_ENTRIES;
   localparam int IW     = $clog2(N);
   localparam int LW     = $clog2(N + 1);
   localparam int LimRst = (N < 64) ? N : 64;

   // limit register and fill count
   logic [LW-1:0] lim_ff, lim_in;
   logic [LW-1:0] used_ff, used_in;

   // compare stage
   logic          cmp_vld_ff;
   gcl_key_type   key_ff;

   // update stage
   logic          upd_vld_ff;
   logic          hit_ff;
   logic          evict_ff;
   logic [IW-1:0] pos_ff;
   logic          upd_go;

   // output register
   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [IndexW-1:0] rsp_index_ff;
   logic              rsp_evicted_ff;
   logic [FontW-1:0]  rsp_font_ff;
   logic [CodeW-1:0]  rsp_code_ff;

   // cell row
   logic              cell_valid [N];
   logic [IW-1:0]     cell_idx [N];
   gcl_key_type       cell_key [N];
   logic [N-1:0]      match_vec;
   logic [N-1:0]      sel_vec;

   logic              acc;
   logic              any_hit;
   logic [IW-1:0]     hit_pos;
   logic [IW-1:0]     miss_pos;
   logic [LW-1:0]     used_dec;
   logic              not_full;
   logic              sel_valid;
   logic [IW-1:0]     sel_idx;
   gcl_key_type       sel_key;
   gcl_key_type       key_in;

   // handshake: a new item may enter only once the previous update lands
   assign upd_go           = upd_vld_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !cmp_vld_ff && (!upd_vld_ff || upd_go);
   assign acc              = req_chan.valid && req_chan.ready;
   assign key_in.font      = req_chan.font_id;
   assign key_in.code      = req_chan.char_code;

   // limit: zero acts as one, clipped to the entry count
   always_comb begin
      if (csr_wr_data == '0) begin
         lim_in = LW'(1);
      end else if (32'(csr_wr_data) > 32'(N)) begin
         lim_in = LW'(N);
      end else begin
         lim_in = LW'(csr_wr_data);
      end
   end

   // row of cells, position 0 fed with the entry being promoted
   for (genvar k = 0; k < N; k++) begin : g_cell
      logic          pv;
      logic [IW-1:0] pi;
      gcl_key_type   pk;

      if (k == 0) begin : g_head
         assign pv = 1'b1;
         assign pi = sel_idx;
         assign pk = key_ff;
      end else begin : g_body
         assign pv = cell_valid[k-1];
         assign pi = cell_idx[k-1];
         assign pk = cell_key[k-1];
      end

      gcl_cell #(
         .IDX_W (IW),
         .POS   (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .clear      (csr_wr_en),
         .update     (upd_go),
         .tgt_pos    (pos_ff),
         .cmp_key    (key_ff),
         .prev_valid (pv),
         .prev_idx   (pi),
         .prev_key   (pk),
         .valid      (cell_valid[k]),
         .idx        (cell_idx[k]),
         .key        (cell_key[k]),
         .match      (match_vec[k]),
         .sel        (sel_vec[k])
      );
   end

   // compare stage: encode hit position, pick the miss position
   always_comb begin
      hit_pos = '0;
      for (int k = 0; k < N; k++) begin
         hit_pos = hit_pos | (match_vec[k] ? IW'(k) : '0);
      end
      any_hit  = |match_vec;
      not_full = (used_ff < lim_ff);
      used_dec = used_ff - LW'(1);
      miss_pos = not_full ? used_ff[IW-1:0] : used_dec[IW-1:0];
   end

   // update stage: read the target cell
   always_comb begin
      sel_valid = 1'b0;
      sel_idx   = '0;
      sel_key   = '0;
      for (int k = 0; k < N; k++) begin
         sel_valid = sel_valid | (sel_vec[k] & cell_valid[k]);
         sel_idx   = sel_idx | (sel_vec[k] ? cell_idx[k] : '0);
         sel_key   = sel_key | (sel_vec[k] ? cell_key[k] : '0);
      end
   end

   // fill count advances on a miss into a fresh entry
   always_comb begin
      used_in = used_ff;
      if (upd_go && !hit_ff && !evict_ff) begin
         used_in = used_ff + LW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         lim_ff       <= LW'(LimRst);
         used_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         upd_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            lim_ff  <= lim_in;
            used_ff <= '0;
         end else begin
            used_ff <= used_in;
         end
         cmp_vld_ff <= acc;
         upd_vld_ff <= cmp_vld_ff || (upd_vld_ff && !upd_go);
         if (upd_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (acc) begin
         key_ff <= key_in;
      end
      if (cmp_vld_ff) begin
         hit_ff   <= any_hit;
         evict_ff <= !any_hit && !not_full;
         pos_ff   <= any_hit ? hit_pos : miss_pos;
      end
      if (upd_go) begin
         rsp_hit_ff     <= hit_ff;
         rsp_index_ff   <= IndexW'(sel_idx);
         rsp_evicted_ff <= evict_ff;
         rsp_font_ff    <= evict_ff ? sel_key.font : '0;
         rsp_code_ff    <= evict_ff ? sel_key.code : '0;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.hit          = rsp_hit_ff;
   assign rsp_chan.entry_index  = rsp_index_ff;
   assign rsp_chan.evicted      = rsp_evicted_ff;
   assign rsp_chan.evicted_font = rsp_font_ff;
   assign rsp_chan.evicted_code = rsp_code_ff;

   `include "assert_macros.svh"

   `ASSERT_CLK(a_stage_excl, clock, reset, cmp_vld_ff |-> !upd_vld_ff, "compare and update stages both busy")
   `ASSERT_CLK(a_one_match, clock, reset, $onehot0(match_vec), "key held in more than one entry")
   `ASSERT_CLK(a_used_lim, clock, reset, used_ff <= lim_ff, "fill count beyond limit")
   `ASSERT_CLK(a_victim, clock, reset, (upd_vld_ff && !hit_ff) |-> (sel_valid == evict_ff), "miss target validity disagrees with eviction")
   `ASSERT_CLK(a_csr_clear, clock, reset, csr_wr_en |=> (used_ff == '0), "csr write did not empty the cache")

endmodule

// ===== tb/tb_glyph_cache_lru_lookup_checker.sv =====
module tb_glyph_cache_lru_lookup_checker #(
   parameter int CACHE_ENTRIES = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   gcl_req_if                       req_mon,
   gcl_rsp_if                       rsp_mon,
   input  logic                     csr_wr_en,
   input  logic [gcl_pkg::CfgW-1:0] csr_wr_data,
   output int                       fail_count,
   output int                       expected_left,
   output int                       lookups_seen,
   output int                       hits_seen,
   output int                       evictions_seen
);
   import gcl_pkg::*;

   localparam int PrintCap = 40;

   // One lookup result as the block should return it
   typedef struct packed {
      logic              hit;
      logic [IndexW-1:0] entry_index;
      logic              evicted;
      logic [FontW-1:0]  evicted_font;
      logic [CodeW-1:0]  evicted_code;
   } glyph_result_type;

   // Shadow copy of the cache; lru_row[0] is the most recent entry
   logic              ent_valid [CACHE_ENTRIES];
   logic [FontW-1:0]  ent_font  [CACHE_ENTRIES];
   logic [CodeW-1:0]  ent_code  [CACHE_ENTRIES];
   int unsigned       lru_row   [CACHE_ENTRIES];
   int unsigned       fill_count;
   logic [CfgW-1:0]   limit_reg;

   glyph_result_type  pending_results [$];

   initial begin
      fail_count     = 0;
      expected_left  = 0;
      lookups_seen   = 0;
      hits_seen      = 0;
      evictions_seen = 0;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      fail_count++;
      if (fail_count <= PrintCap) begin
         $display("MISMATCH at %0t, %s: got %0h, expected %0h", $realtime, what, got, want);
      end
   endtask

   // Empty the cache: no valid entries, recency row back in index order
   function automatic void empty_cache();
      int i;
      for (i = 0; i < CACHE_ENTRIES; i++) begin
         ent_valid[i] = 1'b0;
         ent_font[i]  = '0;
         ent_code[i]  = '0;
         lru_row[i]   = i;
      end
      fill_count = 0;
   endfunction

   // Look a glyph up, update the shadow cache and work out the result
   task automatic lookup_glyph(input logic [FontW-1:0] font, input logic [CodeW-1:0] code,
                               output glyph_result_type res);
      int unsigned lim;
      int unsigned slot;
      int unsigned pos;
      int          i;
      bit          found;
      lim   = (limit_reg == 0) ? 1 : ((limit_reg > CACHE_ENTRIES) ? CACHE_ENTRIES : limit_reg);
      found = 1'b0;
      slot  = 0;
      res   = '0;
      for (i = 0; i < CACHE_ENTRIES; i++) begin
         if (!found && ent_valid[i] && ent_font[i] == font && ent_code[i] == code) begin
            found = 1'b1;
            slot  = i;
         end
      end
      // miss: fresh entry while any remain, else the least recent one goes
      if (!found) begin
         if (fill_count < lim) begin
            slot = fill_count;
            fill_count++;
         end else begin
            pos = (fill_count > 0) ? fill_count - 1 : 0;
            if (pos >= CACHE_ENTRIES) pos = CACHE_ENTRIES - 1;
            slot             = lru_row[pos] % CACHE_ENTRIES;
            res.evicted      = 1'b1;
            res.evicted_font = ent_font[slot];
            res.evicted_code = ent_code[slot];
         end
         ent_valid[slot] = 1'b1;
         ent_font[slot]  = font;
         ent_code[slot]  = code;
      end
      // move the entry to the head of the recency row
      pos = 0;
      while (pos < CACHE_ENTRIES && lru_row[pos] != slot) pos++;
      if (pos < CACHE_ENTRIES) begin
         while (pos > 0) begin
            lru_row[pos] = lru_row[pos-1];
            pos--;
         end
         lru_row[0] = slot;
      end
      res.hit         = found;
      res.entry_index = slot[IndexW-1:0];
   endtask

   // Watch both channels and the register port on every edge
   always @(posedge clock) begin : watch
      glyph_result_type want;
      glyph_result_type got;
      if (reset) begin
         // limit comes out of reset at 64 entries
         limit_reg = CfgW'(64);
         empty_cache();
         pending_results.delete();
      end else begin
         if (csr_wr_en) begin
            limit_reg = csr_wr_data;
            empty_cache();
         end
         if (req_mon.valid && req_mon.ready) begin
            lookup_glyph(req_mon.font_id, req_mon.char_code, want);
            pending_results.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.hit          = rsp_mon.hit;
            got.entry_index  = rsp_mon.entry_index;
            got.evicted      = rsp_mon.evicted;
            got.evicted_font = rsp_mon.evicted_font;
            got.evicted_code = rsp_mon.evicted_code;
            if (pending_results.size() == 0) begin
               report("result with no lookup pending", got.entry_index, 0);
            end else begin
               want = pending_results.pop_front();
               lookups_seen++;
               if (want.hit) hits_seen++;
               if (want.evicted) evictions_seen++;
               if (got.hit !== want.hit) report("hit", got.hit, want.hit);
               if (got.entry_index !== want.entry_index)
                  report("entry_index", got.entry_index, want.entry_index);
               if (got.evicted !== want.evicted) report("evicted", got.evicted, want.evicted);
               if (got.evicted_font !== want.evicted_font)
                  report("evicted_font", got.evicted_font, want.evicted_font);
               if (got.evicted_code !== want.evicted_code)
                  report("evicted_code", got.evicted_code, want.evicted_code);
            end
         end
      end
      expected_left <= pending_results.size();
   end

endmodule

// ===== tb/tb_glyph_cache_lru_lookup_top.sv =====
module tb_glyph_cache_lru_lookup_top;
   import gcl_pkg::*;

   localparam int CACHE_ENTRIES = 64;
   localparam int LONG_HOLD     = 150;
   localparam int TAIL_CYCLES   = 10;
   localparam int NUM_PHASES    = 10;

   logic            clock;
   logic            reset;
   logic            csr_wr_en;
   logic [CfgW-1:0] csr_wr_data;

   gcl_req_if req_chan ();
   gcl_rsp_if rsp_chan ();

   int fail_count;
   int expected_left;
   int lookups_seen;
   int hits_seen;
   int evictions_seen;

   // shared between the request and result sides
   bit sink_idles;
   int hold_requests;

   // request side only
   bit src_idles;
   int burst_left;

   glyph_cache_lru_lookup_top #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tb_glyph_cache_lru_lookup_checker #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .fail_count     (fail_count),
      .expected_left  (expected_left),
      .lookups_seen   (lookups_seen),
      .hits_seen      (hits_seen),
      .evictions_seen (evictions_seen)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #(8 * 400000);
      $display("RESULT: ERROR");
      $finish;
   end

   // Idle length: mostly short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Result side: random stalls, plus long hold-offs on request
   initial begin : result_sink
      int stall_left;
      int holds_done;
      rsp_chan.ready = 1'b0;
      stall_left     = 0;
      holds_done     = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            stall_left = LONG_HOLD;
         end
         if (stall_left > 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left--;
         end else if (sink_idles && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 1'b0;
            stall_left = idle_len() - 1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Offer one item and wait for it to be taken; called at a clock edge
   task automatic send_item(input logic [FontW-1:0] font, input logic [CodeW-1:0] code);
      int gap;
      req_chan.valid     <= 1'b1;
      req_chan.font_id   <= font;
      req_chan.char_code <= code;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      gap = 0;
      if (burst_left > 0) begin
         burst_left--;
      end else if (src_idles && $urandom_range(0, 99) >= 60) begin
         gap = idle_len();
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every result has come back
   task automatic settle_block();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_left != 0) @(posedge clock);
   endtask

   task automatic write_limit(input logic [CfgW-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Stimulus
   initial begin : stimulus
      int              limits [NUM_PHASES];
      logic [FontW-1:0] pool_font [128];
      logic [CodeW-1:0] pool_code [128];
      int              ph;
      int              n;
      int              k;
      int              r;
      int              eff;
      int              items;
      int              pool_n;
      int              hot_n;
      logic [FontW-1:0] f;
      logic [CodeW-1:0] c;

      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = '0;
      req_chan.valid     = 1'b0;
      req_chan.font_id   = '0;
      req_chan.char_code = '0;
      sink_idles         = 1'b0;
      hold_requests      = 0;
      src_idles          = 1'b0;
      burst_left         = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: key extremes at the reset size, one-field differences
      sink_idles <= 1'b1;
      send_item(8'h00, 16'h0000);
      send_item(8'hFF, 16'hFFFF);
      send_item(8'h00, 16'h0000);
      send_item(8'h00, 16'h0001);
      send_item(8'h01, 16'h0000);
      send_item(8'hFF, 16'hFFFF);
      settle_block();

      // zero acts as a single entry: every new key after the first evicts the last one
      write_limit(7'd0);
      send_item(8'h12, 16'h3456);
      send_item(8'h12, 16'h3456);
      send_item(8'hAB, 16'hCDEF);
      send_item(8'h12, 16'h3456);
      settle_block();

      // two entries: the least recent one goes, not the oldest
      write_limit(7'd2);
      send_item(8'h01, 16'h0001);
      send_item(8'h02, 16'h0002);
      send_item(8'h01, 16'h0001);
      send_item(8'h03, 16'h0003);
      send_item(8'h02, 16'h0002);
      settle_block();

      // rewriting the same value still empties the cache
      write_limit(7'd2);
      send_item(8'h02, 16'h0002);
      send_item(8'h01, 16'h0001);
      settle_block();

      // Random phases over several cache sizes, out-of-range values too
      limits = '{64, 1, 2, 3, 127, 0, 65, 8, 0, 0};
      limits[8] = $urandom_range(1, 127);
      limits[9] = $urandom_range(4, 16);
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         settle_block();
         write_limit(limits[ph][CfgW-1:0]);
         eff    = (limits[ph] == 0) ? 1 :
                  ((limits[ph] > CACHE_ENTRIES) ? CACHE_ENTRIES : limits[ph]);
         items  = (eff >= 32) ? 115 : 50;
         pool_n = eff + eff / 2 + 1;
         hot_n  = (pool_n + 3) / 4;
         src_idles  = (ph % 3 != 2);
         sink_idles <= (ph % 3 != 1);
         // key pool: shared fonts and low codes so near-misses turn up
         for (k = 0; k < pool_n; k++) begin
            pool_font[k] = $urandom_range(0, 1) ? FontW'($urandom_range(0, 3)) :
                                                  FontW'($urandom_range(0, 255));
            pool_code[k] = $urandom_range(0, 1) ? CodeW'($urandom_range(0, 15)) :
                                                  CodeW'($urandom_range(0, 65535));
         end
         for (n = 0; n < items; n++) begin
            // long result hold-off while items keep coming back to back
            if (n == 20 && (ph == 0 || ph == 4)) begin
               hold_requests <= hold_requests + 1;
               burst_left = 60;
            end
            // sender pause until the block has drained
            if (n == items / 2) settle_block();
            r = $urandom_range(0, 99);
            if (r < 10) begin
               f = FontW'($urandom_range(0, 255));
               c = CodeW'($urandom_range(0, 65535));
            end else begin
               k = (r < 40) ? $urandom_range(0, hot_n - 1) : $urandom_range(0, pool_n - 1);
               f = pool_font[k];
               c = pool_code[k];
            end
            send_item(f, c);
         end
      end

      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Checked %0d lookups: %0d hits, %0d evictions.", lookups_seen, hits_seen,
               evictions_seen);
      $display("Cache sizes ran from one entry to full, zero and oversized settings included.");
      if (fail_count == 0 && expected_left == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/gcl_pkg.sv
hw/rtl/gcl_req_if.sv
hw/rtl/gcl_rsp_if.sv
hw/rtl/gcl_cell.sv
hw/rtl/glyph_cache_lru_lookup_top.sv
tb/tb_glyph_cache_lru_lookup_checker.sv
tb/tb_glyph_cache_lru_lookup_top.sv
